[rtl/trapezoidal_speed_profile_unit_macros.svh]
// Assertion macros for the trapezoidal speed profile unit.
// Included by files that check their own pipeline behaviour.
`ifndef TRAPEZOIDAL_SPEED_PROFILE_UNIT_MACROS_SVH
`define TRAPEZOIDAL_SPEED_PROFILE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/tsp_pkg.sv]
// Shared types and constants for the trapezoidal speed profile unit.
// No dependencies.
package tsp_pkg;
    localparam int SPEED_W = 16;
    localparam int DIST_W  = 20;
    localparam int ACC_W   = 16;
    // Energy terms: speed^2 is 32 bits, 2*a*x is 41 bits; signed sums need 44.
    localparam int E_W     = 44;
    localparam int SQ_STEPS = E_W / 2;

    localparam logic [2:0] ADDR_TOP_SPEED = 3'h0;
    localparam logic [2:0] ADDR_MAX_ACCEL = 3'h4;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } phase_t;

    typedef logic signed [E_W-1:0] energy_t;

    // Result of the decision stage: radicand, branch and cruise speed.
    typedef struct packed {
        energy_t            radicand;
        phase_t             phase;
        logic [SPEED_W-1:0] cruise;
    } decision_t;
endpackage

[rtl/trapezoidal_speed_profile_unit.sv]
// Trapezoidal speed profile unit, top level.
// Pipeline from input transfer to result: products, decision,
// radicand load, 22 square-root bit stages, output register.
// Throughput: one transfer per cycle; the whole pipeline holds while the output stalls.
// Reset: rst_n asynchronous, clears valid bits and restores register defaults.
module trapezoidal_speed_profile_unit
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_speed[15:0], end_speed[31:16], remaining_distance[51:32],
    // segment_length[71:52]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // speed_command[15:0], profile_phase[17:16], zero fill to 24 bits
    output logic [23:0] m_tdata
);
`include "trapezoidal_speed_profile_unit_macros.svh"

    localparam int DEPTH = SQ_STEPS + 4;

    logic [SPEED_W-1:0] top_speed_reg;
    logic [ACC_W-1:0]   max_accel_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic               advance;
    decision_t          decision;
    logic [SPEED_W-1:0] speed_command;
    phase_t             profile_phase;

    assign pready = 1'b1;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_speed_reg <= 16'd13517;
            max_accel_reg <= 16'd1280;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr)
                ADDR_TOP_SPEED: top_speed_reg <= pwdata[SPEED_W-1:0];
                ADDR_MAX_ACCEL: max_accel_reg <= pwdata[ACC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_TOP_SPEED: prdata = {16'd0, top_speed_reg};
            ADDR_MAX_ACCEL: prdata = {16'd0, max_accel_reg};
            default:        prdata = '0;
        endcase
    end

    // hold the whole pipeline only while a finished result waits
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign m_tvalid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_tvalid};
        end
    end

    tsp_energy u_energy (
        .clk                (clk),
        .advance            (advance),
        .start_speed        (s_tdata[15:0]),
        .end_speed          (s_tdata[31:16]),
        .remaining_distance (s_tdata[51:32]),
        .segment_length     (s_tdata[71:52]),
        .top_speed          (top_speed_reg),
        .max_accel          (max_accel_reg),
        .decision           (decision)
    );

    tsp_sqrt u_sqrt (
        .clk           (clk),
        .advance       (advance),
        .decision      (decision),
        .speed_command (speed_command),
        .profile_phase (profile_phase)
    );

    assign m_tdata = {6'd0, profile_phase, speed_command};

    `TSP_ASSERT_IMP(a_phase_legal, m_tvalid, profile_phase != 2'd3)
    `TSP_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `TSP_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

[rtl/tsp_energy.sv]
// Energy stages: squares the speeds and forms 2*a*x terms, then the decision.
// Depends on tsp_pkg.
module tsp_energy
    import tsp_pkg::*;
(
    input  logic                clk,
    input  logic                advance,
    input  logic [SPEED_W-1:0]  start_speed,
    input  logic [SPEED_W-1:0]  end_speed,
    input  logic [DIST_W-1:0]   remaining_distance,
    input  logic [DIST_W-1:0]   segment_length,
    input  logic [SPEED_W-1:0]  top_speed,
    input  logic [ACC_W-1:0]    max_accel,
    output decision_t           decision
);
    // stage 1: products
    energy_t es_reg, ee_reg, em_reg, el_reg, ed_reg;
    logic [SPEED_W-1:0] xs_reg, xe_reg, top_reg;
    // stage 2: decision
    decision_t dec_reg;
    decision_t dec_next;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            es_reg  <= energy_t'({12'd0, 32'(start_speed) * 32'(start_speed)});
            ee_reg  <= energy_t'({12'd0, 32'(end_speed) * 32'(end_speed)});
            em_reg  <= energy_t'({12'd0, 32'(top_speed) * 32'(top_speed)});
            el_reg  <= energy_t'({3'd0, 36'(max_accel) * 36'(segment_length), 5'b0});
            ed_reg  <= energy_t'({3'd0, 36'(max_accel) * 36'(remaining_distance), 5'b0});
            xs_reg  <= start_speed;
            xe_reg  <= end_speed;
            top_reg <= top_speed;
            dec_reg <= dec_next;
        end
    end

    always_comb
    begin
        energy_t ep, r1, r2, diff;
        logic accel;
        ep = el_reg - ed_reg;
        r1 = em_reg - es_reg;
        r2 = em_reg - ee_reg;
        diff = es_reg - ee_reg;
        if (diff < 0)
        begin
            diff = -diff;
        end
        dec_next.cruise = top_reg;
        if (r1 + r2 < el_reg)
        begin
            if (ep < r1)
            begin
                accel = 1'b1;
                dec_next.phase = PH_ACCEL;
            end
            else if (ep < el_reg - r2)
            begin
                accel = 1'b0;
                dec_next.phase = PH_CRUISE;
            end
            else
            begin
                accel = 1'b0;
                dec_next.phase = PH_DECEL;
            end
        end
        else
        begin
            if (diff < el_reg)
            begin
                accel = ((ep <<< 1) < ee_reg - es_reg + el_reg);
            end
            else
            begin
                accel = !(xs_reg > xe_reg);
            end
            if (accel)
            begin
                dec_next.phase = PH_ACCEL;
            end
            else
            begin
                dec_next.phase = PH_DECEL;
            end
        end
        dec_next.radicand = accel ? (es_reg + ep) : (ee_reg + ed_reg);
    end

    assign decision = dec_reg;
endmodule

[rtl/tsp_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with saturation; cruise passes the cruise speed.
// Depends on tsp_pkg.
module tsp_sqrt
    import tsp_pkg::*;
(
    input  logic                clk,
    input  logic                advance,
    input  decision_t           decision,
    output logic [SPEED_W-1:0]  speed_command,
    output phase_t              profile_phase
);
    localparam int R_W = SQ_STEPS;

    logic [E_W-1:0]     rem_reg   [SQ_STEPS+1];
    logic [R_W-1:0]     root_reg  [SQ_STEPS+1];
    phase_t             ph_reg    [SQ_STEPS+1];
    logic [SPEED_W-1:0] cru_reg   [SQ_STEPS+1];
    logic [SPEED_W-1:0] out_reg;
    phase_t             phout_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= decision.radicand[E_W-1] ? '0 : E_W'(decision.radicand);
            root_reg[0] <= '0;
            ph_reg[0]   <= decision.phase;
            cru_reg[0]  <= decision.cruise;
        end
    end

    // each stage decides one root bit, most significant first
    for (genvar g = 0; g < SQ_STEPS; g++)
    begin : g_step
        localparam int SH = 2 * (SQ_STEPS - 1 - g);
        logic [E_W-1:0] trial;
        logic [E_W-1:0] top_part;
        assign trial = (E_W'({root_reg[g], 2'b01})) << SH;
        assign top_part = rem_reg[g];
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (top_part >= trial)
                begin
                    rem_reg[g+1]  <= top_part - trial;
                    root_reg[g+1] <= {root_reg[g][R_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g+1]  <= top_part;
                    root_reg[g+1] <= {root_reg[g][R_W-2:0], 1'b0};
                end
                ph_reg[g+1]  <= ph_reg[g];
                cru_reg[g+1] <= cru_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phout_reg <= ph_reg[SQ_STEPS];
            if (ph_reg[SQ_STEPS] == PH_CRUISE)
            begin
                out_reg <= cru_reg[SQ_STEPS];
            end
            else if (|root_reg[SQ_STEPS][R_W-1:SPEED_W])
            begin
                out_reg <= '1;
            end
            else
            begin
                out_reg <= root_reg[SQ_STEPS][SPEED_W-1:0];
            end
        end
    end

    assign speed_command = out_reg;
    assign profile_phase = phout_reg;
endmodule

[tb/trapezoidal_speed_profile_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench for the trapezoidal speed profile unit: directed and random segment points,
// checked against an energy-domain predictor. Depends on tsp_pkg and the top level.
module trapezoidal_speed_profile_unit_tb;
    import tsp_pkg::*;

    // Expected result of one segment point.
    typedef struct {
        logic [SPEED_W-1:0] speed;
        phase_t             phase;
    } profile_point_t;

    // Scoreboard: holds the register copy, predicts each transfer and checks results.
    class profile_scoreboard;
        logic [15:0]    top_speed_q;
        logic [15:0]    max_accel_q;
        profile_point_t pending_q[$];
        int             mismatches;

        function new();
            top_speed_q = 16'd13517;
            max_accel_q = 16'd1280;
            mismatches  = 0;
        endfunction

        function logic [SPEED_W-1:0] speed_from_energy(longint e);
            longint unsigned n;
            longint unsigned root;
            longint unsigned b;
            if (e < 0)
                return '0;
            n    = e;
            root = 0;
            b    = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= root + b)
                begin
                    n    = n - (root + b);
                    root = (root >> 1) + b;
                end
                else
                    root = root >> 1;
                b = b >> 2;
            end
            if (root > 64'hFFFF)
                root = 64'hFFFF;
            return root[SPEED_W-1:0];
        endfunction

        function void note_point(logic [71:0] d);
            longint es, ee, em, el, ed, ep, r1, r2, diff;
            logic [15:0] xs, xe;
            bit rising;
            profile_point_t p;
            xs = d[15:0];
            xe = d[31:16];
            es = longint'(xs) * longint'(xs);
            ee = longint'(xe) * longint'(xe);
            em = longint'(top_speed_q) * longint'(top_speed_q);
            el = (longint'(max_accel_q) * longint'(d[71:52])) <<< 5;
            ed = (longint'(max_accel_q) * longint'(d[51:32])) <<< 5;
            ep = el - ed;
            r1 = em - es;
            r2 = em - ee;
            if (r1 + r2 < el)
            begin
                if (ep < r1)
                begin
                    p.speed = speed_from_energy(es + ep);
                    p.phase = PH_ACCEL;
                end
                else if (ep < el - r2)
                begin
                    p.speed = top_speed_q;
                    p.phase = PH_CRUISE;
                end
                else
                begin
                    p.speed = speed_from_energy(ee + ed);
                    p.phase = PH_DECEL;
                end
            end
            else
            begin
                diff = (es > ee) ? es - ee : ee - es;
                if (diff < el)
                    rising = (2 * ep < ee - es + el);
                else
                    rising = !(xs > xe);
                if (rising)
                begin
                    p.speed = speed_from_energy(es + ep);
                    p.phase = PH_ACCEL;
                end
                else
                begin
                    p.speed = speed_from_energy(ee + ed);
                    p.phase = PH_DECEL;
                end
            end
            pending_q.insert(pending_q.size(), p);
        endfunction

        function void check_result(logic [23:0] r);
            profile_point_t p;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", r);
                return;
            end
            p = pending_q.pop_front();
            if (r[15:0] !== p.speed || r[17:16] !== p.phase || r[23:18] !== 6'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected speed %h phase %0d, got speed %h phase %0d",
                             p.speed, p.phase, r[15:0], r[17:16]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    profile_scoreboard sb;
    bit                calm;     // no idling on either side while set

    trapezoidal_speed_profile_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Ready side: stall at random, except during the calm stretch.
    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // Check every result transfer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Register write with a setup and an access phase; hold the bus idle outside it.
    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_TOP_SPEED)
            sb.top_speed_q = value;
        else if (addr == ADDR_MAX_ACCEL)
            sb.max_accel_q = value;
    endtask

    // Present one point and hold it until its transfer; idle beforehand at random.
    task automatic send_point(input logic [15:0] xs, input logic [15:0] xe,
                              input logic [19:0] rem, input logic [19:0] len);
        while (!calm && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, rem, xe, xs};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_point({len, rem, xe, xs});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random point: lengths mostly in range of the ramps, remaining mostly within length.
    task automatic random_point();
        logic [19:0] len, rem;
        logic [15:0] xs, xe;
        xs = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16000));
        xe = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16000));
        case ($urandom_range(3))
            0: len = 20'($urandom);
            1: len = 20'($urandom_range(0, 4096));
            default: len = 20'($urandom_range(0, 65536));
        endcase
        rem = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(0, len));
        send_point(xs, xe, rem, len);
    endtask

    initial
    begin
        logic [15:0] top_set[4];
        logic [15:0] acc_set[4];
        sb       = new();
        calm     = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        top_set  = '{16'hFFFF, 16'd0, 16'd8192, 16'd13517};
        acc_set  = '{16'hFFFF, 16'd1, 16'd300, 16'd1280};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at reset settings: extremes, cruise, triangle, single ramp.
        send_point(16'd0, 16'd0, 20'd0, 20'd0);
        send_point(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
        send_point(16'd0, 16'd0, 20'd409600, 20'd819200);
        send_point(16'd0, 16'd0, 20'd4000, 20'd819200);
        send_point(16'd0, 16'd0, 20'd815000, 20'd819200);
        send_point(16'd0, 16'd0, 20'd2048, 20'd4096);
        send_point(16'd0, 16'd0, 20'd1000, 20'd4096);
        send_point(16'd8000, 16'd0, 20'd100, 20'd200);
        send_point(16'd0, 16'd8000, 20'd100, 20'd200);
        send_point(16'd20000, 16'd0, 20'd409600, 20'd819200);
        send_point(16'd0, 16'd0, 20'hFFFFF, 20'd100);
        send_point(16'd4000, 16'd4000, 20'd50, 20'd100);
        send_point(16'hFFFF, 16'd0, 20'd0, 20'hFFFFF);
        send_point(16'h5555, 16'hAAAA, 20'h55555, 20'hAAAAA);
        send_point(16'hAAAA, 16'h5555, 20'hAAAAA, 20'h55555);

        // Hold until every result is back, then sweep the register settings.
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(ADDR_TOP_SPEED, top_set[ph]);
            write_reg(ADDR_MAX_ACCEL, acc_set[ph]);
            for (int i = 0; i < 170; i++)
            begin
                calm = (ph == 2 && i >= 40 && i < 120);
                random_point();
            end
            calm = 1'b0;
            drain();
        end
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_energy.sv
rtl/tsp_sqrt.sv
rtl/trapezoidal_speed_profile_unit.sv
tb/trapezoidal_speed_profile_unit_tb.sv
